>>> hdl/lsps_pkg.sv
// Package for the looped sample playback sequencer.
// Holds the transaction structs, phase encoding, register indexes and reset values.
// No dependencies.
package lsps_pkg;

    localparam int LSPS_ADDR_W_DEF = 16;
    localparam int LSPS_CFG_IDX_W  = 3;
    localparam int LSPS_CFG_DATA_W = 16;
    localparam int LSPS_FIELD_W    = 16;
    localparam int LSPS_TICK_W     = 8;

    // Register indexes on the configuration port.
    localparam logic [LSPS_CFG_IDX_W-1:0] CFG_BELL_LOOP_LEN   = 3'd0;
    localparam logic [LSPS_CFG_IDX_W-1:0] CFG_BELL_TOTAL_LEN  = 3'd1;
    localparam logic [LSPS_CFG_IDX_W-1:0] CFG_HORN_LOOP_START = 3'd2;
    localparam logic [LSPS_CFG_IDX_W-1:0] CFG_HORN_LOOP_END   = 3'd3;
    localparam logic [LSPS_CFG_IDX_W-1:0] CFG_HORN_TOTAL_LEN  = 3'd4;
    localparam logic [LSPS_CFG_IDX_W-1:0] CFG_RELEASE_TICKS   = 3'd5;

    // Register values after reset.
    localparam logic [LSPS_FIELD_W-1:0] RST_BELL_LOOP_LEN   = 16'd2054;
    localparam logic [LSPS_FIELD_W-1:0] RST_BELL_TOTAL_LEN  = 16'd4096;
    localparam logic [LSPS_FIELD_W-1:0] RST_HORN_LOOP_START = 16'd0;
    localparam logic [LSPS_FIELD_W-1:0] RST_HORN_LOOP_END   = 16'd4096;
    localparam logic [LSPS_FIELD_W-1:0] RST_HORN_TOTAL_LEN  = 16'd4096;
    localparam logic [LSPS_TICK_W-1:0]  RST_RELEASE_TICKS   = 8'd2;

    // Item kinds.
    localparam logic OP_SAMPLE_TICK = 1'b0;
    localparam logic OP_SYSTEM_TICK = 1'b1;

    // Phase codes as they appear on phase_out.
    localparam logic [1:0] PHASE_CODE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_CODE_HELD    = 2'd1;
    localparam logic [1:0] PHASE_CODE_RELEASE = 2'd2;
    localparam logic [1:0] PHASE_CODE_TAIL    = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HELD    = 4'b0010,
        PH_RELEASE = 4'b0100,
        PH_TAIL    = 4'b1000
    } lsps_phase_t;

    typedef struct packed {
        logic opcode;
        logic button_pressed;
        logic horn_mode;
    } lsps_in_t;

    typedef struct packed {
        logic                    sample_valid;
        logic [LSPS_FIELD_W-1:0] sample_address;
        logic                    horn_playing;
        logic [1:0]              phase_out;
        logic                    power_hold;
    } lsps_out_t;

    function automatic logic [1:0] phase_code(input lsps_phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE:    code = PHASE_CODE_IDLE;
            PH_HELD:    code = PHASE_CODE_HELD;
            PH_RELEASE: code = PHASE_CODE_RELEASE;
            PH_TAIL:    code = PHASE_CODE_TAIL;
            default:    code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> hdl/looped_sample_playback_sequencer.sv
// Top level of the looped sample playback sequencer.
// Depends on lsps_pkg for the transaction structs, phase codes and register indexes.

// Every input transaction yields exactly one result transaction. The phase update,
// position advance and loop wrap for an item are done in a single pass of logic
// between the state registers and the output register, so a new item is accepted
// in every cycle as long as the output register is empty or being drained in that
// cycle. Configuration writes are accepted in any cycle and must only be issued
// while no item is in flight. A press latches bell or horn and starts playback from
// address zero; holding the button loops the sound; a release longer than
// release_ticks system ticks plays the tail to its total length and then returns
// to idle. There is no clearing pass after reset.
module looped_sample_playback_sequencer
    import lsps_pkg::*;
#(
    parameter int ADDRESS_WIDTH = LSPS_ADDR_W_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lsps_in_t                   s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lsps_out_t                  m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [LSPS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [LSPS_CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = ADDRESS_WIDTH;
    localparam int CMP_W = (AW > LSPS_FIELD_W) ? AW : LSPS_FIELD_W;

    // Configuration registers.
    logic [LSPS_FIELD_W-1:0] bell_loop_len_reg;
    logic [LSPS_FIELD_W-1:0] bell_total_len_reg;
    logic [LSPS_FIELD_W-1:0] horn_loop_start_reg;
    logic [LSPS_FIELD_W-1:0] horn_loop_end_reg;
    logic [LSPS_FIELD_W-1:0] horn_total_len_reg;
    logic [LSPS_TICK_W-1:0]  release_ticks_reg;

    // Playback state.
    lsps_phase_t             phase_reg, phase_next;
    logic                    horn_reg, horn_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [LSPS_TICK_W-1:0]  tick_reg, tick_next;
    logic [LSPS_TICK_W-1:0]  stamp_reg, stamp_next;

    // Output stage.
    logic                    m_valid_reg, m_valid_next;
    lsps_out_t               m_data_reg, m_data_next;

    // Intermediate values for one item.
    lsps_phase_t             phase_mid;
    logic [AW-1:0]           pos_mid;
    logic [AW-1:0]           pos_inc;
    logic [CMP_W-1:0]        pos_mid_ext, pos_inc_ext;
    logic [CMP_W-1:0]        loop_end_ext, total_ext, start_ext, addr_ext;
    logic [LSPS_TICK_W-1:0]  elapsed;
    logic                    loop_wrap;
    logic                    smp_valid;
    logic [AW-1:0]           smp_addr;
    logic                    s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bell_loop_len_reg   <= RST_BELL_LOOP_LEN;
            bell_total_len_reg  <= RST_BELL_TOTAL_LEN;
            horn_loop_start_reg <= RST_HORN_LOOP_START;
            horn_loop_end_reg   <= RST_HORN_LOOP_END;
            horn_total_len_reg  <= RST_HORN_TOTAL_LEN;
            release_ticks_reg   <= RST_RELEASE_TICKS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BELL_LOOP_LEN:   bell_loop_len_reg   <= cfg_data;
                CFG_BELL_TOTAL_LEN:  bell_total_len_reg  <= cfg_data;
                CFG_HORN_LOOP_START: horn_loop_start_reg <= cfg_data;
                CFG_HORN_LOOP_END:   horn_loop_end_reg   <= cfg_data;
                CFG_HORN_TOTAL_LEN:  horn_total_len_reg  <= cfg_data;
                CFG_RELEASE_TICKS:   release_ticks_reg   <= cfg_data[LSPS_TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        tick_next  = tick_reg + LSPS_TICK_W'(s_data.opcode == OP_SYSTEM_TICK);
        stamp_next = stamp_reg;
        horn_next  = horn_reg;
        phase_mid  = phase_reg;
        pos_mid    = pos_reg;
        elapsed    = tick_next - stamp_reg;

        case (phase_reg)
            PH_IDLE: begin
                if (s_data.button_pressed) begin
                    phase_mid = PH_HELD;
                    horn_next = s_data.horn_mode;
                    pos_mid   = '0;
                end
            end
            PH_HELD: begin
                if (!s_data.button_pressed) begin
                    phase_mid  = PH_RELEASE;
                    stamp_next = tick_next;
                end
            end
            PH_RELEASE: begin
                if (s_data.button_pressed) begin
                    phase_mid = PH_HELD;
                end else if (elapsed > release_ticks_reg) begin
                    phase_mid = PH_TAIL;
                end
            end
            default: ;
        endcase

        pos_inc      = pos_mid + AW'(1);
        pos_mid_ext  = CMP_W'(pos_mid);
        pos_inc_ext  = CMP_W'(pos_inc);
        loop_end_ext = CMP_W'(horn_next ? horn_loop_end_reg : bell_loop_len_reg);
        total_ext    = CMP_W'(horn_next ? horn_total_len_reg : bell_total_len_reg);
        start_ext    = CMP_W'(horn_loop_start_reg);
        // An advance that overflows the position counter also wraps to the loop start.
        loop_wrap    = (pos_inc_ext >= loop_end_ext) || (pos_inc == '0);

        phase_next = phase_mid;
        pos_next   = pos_mid;
        smp_valid  = 1'b0;
        smp_addr   = '0;

        if (s_data.opcode == OP_SAMPLE_TICK && phase_mid != PH_IDLE) begin
            if (phase_mid == PH_TAIL) begin
                if (pos_mid_ext >= total_ext) begin
                    phase_next = PH_IDLE;
                end else begin
                    smp_valid = 1'b1;
                    smp_addr  = pos_mid;
                    pos_next  = pos_inc;
                    if (pos_inc_ext >= total_ext || pos_inc == '0) begin
                        phase_next = PH_IDLE;
                    end
                end
            end else begin
                smp_valid = 1'b1;
                smp_addr  = pos_mid;
                if (loop_wrap) begin
                    pos_next = horn_next ? start_ext[AW-1:0] : '0;
                end else begin
                    pos_next = pos_inc;
                end
            end
        end

        addr_ext                   = CMP_W'(smp_addr);
        m_data_next.sample_valid   = smp_valid;
        m_data_next.sample_address = addr_ext[LSPS_FIELD_W-1:0];
        m_data_next.horn_playing   = horn_next;
        m_data_next.phase_out      = phase_code(phase_next);
        m_data_next.power_hold     = (phase_next != PH_IDLE);

        m_valid_next = s_fire || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            horn_reg    <= 1'b0;
            pos_reg     <= '0;
            tick_reg    <= '0;
            stamp_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                phase_reg <= phase_next;
                horn_reg  <= horn_next;
                pos_reg   <= pos_next;
                tick_reg  <= tick_next;
                stamp_reg <= stamp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

>>> hdl/lsps_checker.sv
// Port-level checker for the looped sample playback sequencer, with its bind statement.
// Depends on lsps_pkg and on the top-level module looped_sample_playback_sequencer.
module lsps_checker
    import lsps_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input lsps_out_t m_data
);

    // No result can be pending in the cycle after reset.
    a_no_result_after_reset: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // A result transaction that is not taken stays offered.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its payload.
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    // An empty sample slot carries address zero.
    a_idle_address_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.sample_valid |-> m_data.sample_address == '0)
        else $error("address set without a sample");

    // Power is held exactly while playback is not idle.
    a_power_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.power_hold == (m_data.phase_out != PHASE_CODE_IDLE))
        else $error("power hold disagrees with phase");

endmodule

bind looped_sample_playback_sequencer lsps_checker u_lsps_checker (.*);

>>> test/looped_sample_playback_sequencer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the looped sample playback sequencer.
// Depends on lsps_pkg and looped_sample_playback_sequencer; drives random and directed
// button gestures and checks every result against a cycle-free playback predictor.
module looped_sample_playback_sequencer_test;
    import lsps_pkg::*;

    localparam int LONG_HOLD_CYCLES = 40;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int PHASE_ITEMS      = 135;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    lsps_in_t                   s_data;
    logic                       m_valid;
    logic                       m_ready;
    lsps_out_t                  m_data;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [LSPS_CFG_IDX_W-1:0]  cfg_index;
    logic [LSPS_CFG_DATA_W-1:0] cfg_data;

    // Tracks register contents and playback state, and holds the outputs still owed.
    class playback_scoreboard;
        bit [15:0] bell_loop_len;
        bit [15:0] bell_total_len;
        bit [15:0] horn_loop_start;
        bit [15:0] horn_loop_end;
        bit [15:0] horn_total_len;
        bit [7:0]  release_ticks;

        bit [1:0]  seq_phase;
        bit        sel_horn;
        bit [15:0] play_pos;
        bit [7:0]  tick_cnt;
        bit [7:0]  release_mark;

        lsps_out_t predicted_outputs[$];
        int        errors;
        int        results_checked;
        int        samples_played;

        function new();
            bell_loop_len   = RST_BELL_LOOP_LEN;
            bell_total_len  = RST_BELL_TOTAL_LEN;
            horn_loop_start = RST_HORN_LOOP_START;
            horn_loop_end   = RST_HORN_LOOP_END;
            horn_total_len  = RST_HORN_TOTAL_LEN;
            release_ticks   = RST_RELEASE_TICKS;
            seq_phase       = PHASE_CODE_IDLE;
            sel_horn        = 1'b0;
            play_pos        = '0;
            tick_cnt        = '0;
            release_mark    = '0;
            errors          = 0;
            results_checked = 0;
            samples_played  = 0;
        endfunction

        function void write_reg(logic [LSPS_CFG_IDX_W-1:0] idx, logic [LSPS_CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BELL_LOOP_LEN:   bell_loop_len   = value;
                CFG_BELL_TOTAL_LEN:  bell_total_len  = value;
                CFG_HORN_LOOP_START: horn_loop_start = value;
                CFG_HORN_LOOP_END:   horn_loop_end   = value;
                CFG_HORN_TOTAL_LEN:  horn_total_len  = value;
                CFG_RELEASE_TICKS:   release_ticks   = value[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return predicted_outputs.size();
        endfunction

        // Advances the playback state by one input transaction and queues its output.
        function void note_item(lsps_in_t item);
            lsps_out_t out;
            bit [15:0] total;
            bit [15:0] loop_end;
            bit [15:0] next_pos;
            bit [7:0]  elapsed;
            out = '0;
            if (item.opcode == OP_SYSTEM_TICK)
                tick_cnt++;
            case (seq_phase)
                PHASE_CODE_IDLE: begin
                    if (item.button_pressed) begin
                        seq_phase = PHASE_CODE_HELD;
                        sel_horn  = item.horn_mode;
                        play_pos  = '0;
                    end
                end
                PHASE_CODE_HELD: begin
                    if (!item.button_pressed) begin
                        seq_phase    = PHASE_CODE_RELEASE;
                        release_mark = tick_cnt;
                    end
                end
                PHASE_CODE_RELEASE: begin
                    elapsed = tick_cnt - release_mark;
                    if (item.button_pressed)
                        seq_phase = PHASE_CODE_HELD;
                    else if (elapsed > release_ticks)
                        seq_phase = PHASE_CODE_TAIL;
                end
                default: ;
            endcase
            if (item.opcode == OP_SAMPLE_TICK && seq_phase != PHASE_CODE_IDLE) begin
                if (seq_phase == PHASE_CODE_TAIL) begin
                    total = sel_horn ? horn_total_len : bell_total_len;
                    if (play_pos >= total) begin
                        seq_phase = PHASE_CODE_IDLE;
                    end else begin
                        out.sample_valid   = 1'b1;
                        out.sample_address = play_pos;
                        play_pos++;
                        // The tail also stops if the address counter rolls over.
                        if (play_pos >= total || play_pos == 0)
                            seq_phase = PHASE_CODE_IDLE;
                    end
                end else begin
                    out.sample_valid   = 1'b1;
                    out.sample_address = play_pos;
                    next_pos = play_pos + 16'd1;
                    loop_end = sel_horn ? horn_loop_end : bell_loop_len;
                    if (next_pos >= loop_end || next_pos == 0)
                        next_pos = sel_horn ? horn_loop_start : 16'd0;
                    play_pos = next_pos;
                end
            end
            out.horn_playing = sel_horn;
            out.phase_out    = seq_phase;
            out.power_hold   = (seq_phase != PHASE_CODE_IDLE);
            if (out.sample_valid)
                samples_played++;
            predicted_outputs.push_back(out);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(lsps_out_t got);
            lsps_out_t want;
            if (predicted_outputs.size() == 0) begin
                $error("unexpected result transaction: sample_address %0d", got.sample_address);
                errors++;
                return;
            end
            want = predicted_outputs.pop_front();
            results_checked++;
            compare_field("sample_valid", want.sample_valid, got.sample_valid);
            compare_field("sample_address", want.sample_address, got.sample_address);
            compare_field("horn_playing", want.horn_playing, got.horn_playing);
            compare_field("phase_out", want.phase_out, got.phase_out);
            compare_field("power_hold", want.power_hold, got.power_hold);
        endfunction
    endclass

    playback_scoreboard board = new();

    bit idle_on       = 1'b1;
    bit long_hold_req = 1'b0;
    int items_accepted = 0;
    int long_holds     = 0;
    int settings_used  = 1;

    looped_sample_playback_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Results are checked before the same edge's input is noted, so a result can never
    // be matched against the transaction accepted at that very edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_data);
            if (s_valid && s_ready) begin
                board.note_item(s_data);
                items_accepted++;
            end
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("looped_sample_playback_sequencer: mismatch");
                $finish;
            end
        end
    end

    initial begin : receiver
        int stall;
        stall = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
                long_holds++;
                m_ready <= 1'b1;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                stall = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic bit coin(int one_in);
        return $urandom_range(0, one_in - 1) == 0;
    endfunction

    // Offers one input transaction until it is taken, then may drop s_valid for a random gap.
    task automatic send_item(input logic op, input logic button, input logic mode);
        lsps_in_t item;
        item.opcode         = op;
        item.button_pressed = button;
        item.horn_mode      = mode;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (idle_on && coin(6)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [LSPS_CFG_IDX_W-1:0] idx,
                             input logic [LSPS_CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [15:0] bell_sustain, input logic [15:0] bell_total,
                                 input logic [15:0] horn_start, input logic [15:0] horn_end,
                                 input logic [15:0] horn_total, input logic [15:0] rel_ticks);
        write_reg(CFG_BELL_LOOP_LEN, bell_sustain);
        write_reg(CFG_BELL_TOTAL_LEN, bell_total);
        write_reg(CFG_HORN_LOOP_START, horn_start);
        write_reg(CFG_HORN_LOOP_END, horn_end);
        write_reg(CFG_HORN_TOTAL_LEN, horn_total);
        write_reg(CFG_RELEASE_TICKS, rel_ticks);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // A press, a held stretch, a release that may bounce, then the tail.
    task automatic play_gesture();
        int hold_n;
        int rel_n;
        int tail_n;
        hold_n = $urandom_range(0, 24);
        send_item(OP_SAMPLE_TICK, 1'b1, coin(2));
        repeat (hold_n) send_item(coin(8) ? OP_SYSTEM_TICK : OP_SAMPLE_TICK, 1'b1, coin(2));
        do begin
            rel_n = $urandom_range(1, 12);
            repeat (rel_n) send_item(coin(2) ? OP_SYSTEM_TICK : OP_SAMPLE_TICK, 1'b0, coin(2));
            if (coin(4))
                repeat ($urandom_range(1, 4)) send_item(OP_SAMPLE_TICK, 1'b1, coin(2));
            else
                break;
        end while (1);
        tail_n = $urandom_range(0, 40);
        repeat (tail_n) send_item(coin(12) ? OP_SYSTEM_TICK : OP_SAMPLE_TICK, coin(16), coin(2));
    endtask

    task automatic run_random(input int target);
        int start;
        start = items_accepted;
        while (items_accepted - start < target) begin
            if (coin(7))
                repeat ($urandom_range(1, 8)) send_item(coin(2), coin(2), coin(2));
            else
                play_gesture();
        end
    endtask

    initial begin : stimulus
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BELL_LOOP_LEN;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register values after reset: idle tick, press on a system tick, release, bounce.
        send_item(OP_SAMPLE_TICK, 1'b0, 1'b0);
        send_item(OP_SYSTEM_TICK, 1'b1, 1'b1);
        send_item(OP_SAMPLE_TICK, 1'b1, 1'b0);
        send_item(OP_SAMPLE_TICK, 1'b0, 1'b0);
        send_item(OP_SYSTEM_TICK, 1'b1, 1'b0);
        send_item(OP_SAMPLE_TICK, 1'b0, 1'b1);
        drain_results();

        // Short loops: bell loop wrap, bell tail with an ignored press, then a fresh bell press.
        load_settings(16'd3, 16'd6, 16'd2, 16'd5, 16'd7, 16'd0);
        send_item(OP_SYSTEM_TICK, 1'b0, 1'b0);
        send_item(OP_SAMPLE_TICK, 1'b1, 1'b0);
        repeat (3) send_item(OP_SAMPLE_TICK, 1'b0, 1'b0);
        repeat (4) send_item(OP_SAMPLE_TICK, 1'b1, 1'b0);
        send_item(OP_SAMPLE_TICK, 1'b0, 1'b1);
        send_item(OP_SYSTEM_TICK, 1'b0, 1'b1);
        repeat (4) send_item(OP_SAMPLE_TICK, 1'b0, 1'b0);
        send_item(OP_SAMPLE_TICK, 1'b1, 1'b1);
        repeat (3) send_item(OP_SAMPLE_TICK, 1'b1, 1'b0);
        run_random(PHASE_ITEMS);
        drain_results();

        // Upper extremes: the horn loop restarts at the top address and the tail never commits.
        load_settings(16'd65535, 16'd1, 16'd65535, 16'd1, 16'd65535, 16'd255);
        run_random(PHASE_ITEMS);
        drain_results();

        // Horn tail runs past the loop end; the output is held off while input is still offered.
        idle_on = coin(4) ? 1'b0 : 1'b1;
        load_settings(16'd37, 16'd50, 16'd10, 16'd40, 16'd45, 16'd3);
        long_hold_req = 1'b1;
        repeat (16) send_item(OP_SAMPLE_TICK, 1'b1, coin(2));
        run_random(PHASE_ITEMS);
        drain_results();

        // Bell loop longer than its total, and a horn loop start at its end.
        idle_on = 1'b1;
        load_settings(16'd8, 16'd4, 16'd7, 16'd7, 16'd20, 16'd1);
        run_random(PHASE_ITEMS);
        drain_results();

        // Lower extremes.
        load_settings(16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd0);
        run_random(PHASE_ITEMS);
        drain_results();

        idle_on = coin(3) ? 1'b0 : 1'b1;
        load_settings(16'($urandom_range(1, 12)), 16'($urandom_range(1, 24)),
                      16'($urandom_range(0, 12)), 16'($urandom_range(1, 12)),
                      16'($urandom_range(1, 24)), 16'($urandom_range(0, 4)));
        run_random(PHASE_ITEMS);
        drain_results();

        // Closing stretch runs at full rate on both sides.
        idle_on = 1'b0;
        load_settings(16'($urandom_range(1, 12)), 16'($urandom_range(1, 24)),
                      16'($urandom_range(0, 12)), 16'($urandom_range(1, 12)),
                      16'($urandom_range(1, 24)), 16'($urandom_range(0, 4)));
        run_random(PHASE_ITEMS);
        drain_results();

        $display("Played %0d input transactions into %0d checked results (%0d samples)",
                 items_accepted, board.results_checked, board.samples_played);
        $display("across %0d register settings with %0d long output stalls.",
                 settings_used, long_holds);
        if (board.errors == 0 && board.pending() == 0)
            $display("looped_sample_playback_sequencer: match");
        else
            $display("looped_sample_playback_sequencer: mismatch");
        $finish;
    end

endmodule

>>> sim.f
hdl/lsps_pkg.sv
hdl/looped_sample_playback_sequencer.sv
hdl/lsps_checker.sv
test/looped_sample_playback_sequencer_test.sv
